// ===== hdl/tssc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tssc_pkg: shared types and constants of the top-k score selector
// Widths, entry and request structs, empty marker and tally helpers.
// ----------------------------------------------------------------------------
package tssc_pkg;

   // list depth and label width
   localparam int TOP_K      = 5;
   localparam int LABEL_BITS = 24;
   localparam int SCORE_BITS = 32;
   localparam int TALLY_BITS = 48;
   localparam int RANK_BITS  = (TOP_K > 1) ? $clog2(TOP_K) : 1;

   localparam logic [RANK_BITS-1:0]  LAST_RANK  = RANK_BITS'(TOP_K - 1);
   localparam logic [TALLY_BITS-1:0] TALLY_MAX  = {TALLY_BITS{1'b1}};
   localparam logic [SCORE_BITS-1:0] EMPTY_SCORE = {1'b1, {(SCORE_BITS-1){1'b0}}};

   // one list entry
   typedef struct packed {
      logic [SCORE_BITS-1:0] score;
      logic [LABEL_BITS-1:0] label;
   } entry_type;

   localparam entry_type EMPTY_ENTRY = '{score: EMPTY_SCORE, label: '0};

   // request broadcast to every cell
   typedef struct packed {
      logic                  valid;
      logic                  first;
      logic [SCORE_BITS-1:0] score;
      logic [LABEL_BITS-1:0] label;
   } ins_type;

   // four confusion counters
   typedef struct packed {
      logic [TALLY_BITS-1:0] tp;
      logic [TALLY_BITS-1:0] fn;
      logic [TALLY_BITS-1:0] fp;
      logic [TALLY_BITS-1:0] tn;
   } tally_type;

   // saturating increment
   function automatic logic [TALLY_BITS-1:0] sat_inc(input logic [TALLY_BITS-1:0] v);
      sat_inc = (v == TALLY_MAX) ? TALLY_MAX : v + TALLY_BITS'(1);
   endfunction

endpackage
`default_nettype wire

// ===== hdl/tssc_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tssc_req_if: score request channel
// Valid/ready channel carrying one label score and its row flags.
// ----------------------------------------------------------------------------
interface tssc_req_if;
   import tssc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [SCORE_BITS-1:0] score;
   logic                  is_true_label;
   logic                  first_of_row;
   logic                  last_of_row;

   modport source (output valid, output score, output is_true_label,
                   output first_of_row, output last_of_row, input ready);
   modport sink   (input valid, input score, input is_true_label,
                   input first_of_row, input last_of_row, output ready);
endinterface
`default_nettype wire

// ===== hdl/tssc_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tssc_rsp_if: ranked result channel
// Valid/ready channel carrying one list entry and the running tallies.
// ----------------------------------------------------------------------------
interface tssc_rsp_if;
   import tssc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [RANK_BITS-1:0]  rank;
   logic [SCORE_BITS-1:0] best_score;
   logic [LABEL_BITS-1:0] best_label;
   logic                  last_rank;
   logic [TALLY_BITS-1:0] true_pos_total;
   logic [TALLY_BITS-1:0] false_neg_total;
   logic [TALLY_BITS-1:0] false_pos_total;
   logic [TALLY_BITS-1:0] true_neg_total;

   modport source (output valid, output rank, output best_score, output best_label,
                   output last_rank, output true_pos_total, output false_neg_total,
                   output false_pos_total, output true_neg_total, input ready);
   modport sink   (input valid, input rank, input best_score, input best_label,
                   input last_rank, input true_pos_total, input false_neg_total,
                   input false_pos_total, input true_neg_total, output ready);
endinterface
`default_nettype wire

// ===== hdl/tssc_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tssc_cell: one rank of the insertion list
// Holds one entry. When the new score lands here it takes the new entry; when
// it lands above, it takes the upper neighbor's score with the label carried
// down the chain. It keeps a shadow copy that shifts up while results drain.
// ----------------------------------------------------------------------------
module tssc_cell import tssc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ins_type               ins,
   input  wire entry_type             up_ent,
   input  wire logic                  up_gt,
   input  wire logic [LABEL_BITS-1:0] up_carry,
   output entry_type                  eff_ent,
   output logic                       gt,
   output logic [LABEL_BITS-1:0]      carry,
   input  wire logic                  snap,
   input  wire logic                  pop,
   input  wire entry_type             dn_shadow,
   output entry_type                  shadow
);

   entry_type ent_ff, ent_in;
   entry_type shadow_ff, shadow_in;
   logic      swap;

   // entry as seen by this request, cleared at row start
   assign eff_ent = ins.first ? EMPTY_ENTRY : ent_ff;
   assign gt      = $signed(ins.score) > $signed(eff_ent.score);

   // list is kept descending, so the carried entry moves on only past a lower score
   assign swap = $signed(up_ent.score) > $signed(eff_ent.score);

   // take the carried entry, insert here, or keep
   always_comb begin
      ent_in = ent_ff;
      if (ins.valid) begin
         if (up_gt) begin
            if (swap) begin
               ent_in = '{score: up_ent.score, label: up_carry};
            end else begin
               ent_in = eff_ent;
            end
         end else if (gt) begin
            ent_in = '{score: ins.score, label: ins.label};
         end else begin
            ent_in = eff_ent;
         end
      end
   end

   // label handed to the next rank: new label until it lands, then the displaced one
   always_comb begin
      if (up_gt) begin
         carry = swap ? eff_ent.label : up_carry;
      end else if (gt) begin
         carry = eff_ent.label;
      end else begin
         carry = ins.label;
      end
   end

   // shadow loads the updated list, then shifts toward rank zero
   always_comb begin
      shadow_in = shadow_ff;
      if (snap) begin
         shadow_in = ent_in;
      end else if (pop) begin
         shadow_in = dn_shadow;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff <= EMPTY_ENTRY;
      end else begin
         ent_ff <= ent_in;
      end
   end

   always_ff @(posedge clock) begin
      shadow_ff <= shadow_in;
   end

   assign shadow = shadow_ff;

endmodule
`default_nettype wire

// ===== hdl/tssc_tally.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tssc_tally: saturating confusion counters
// Counts true/false positives and negatives, positive meaning score above 0.
// ----------------------------------------------------------------------------
module tssc_tally import tssc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  valid,
   input  wire logic                  truth,
   input  wire logic [SCORE_BITS-1:0] score,
   output tally_type                  tally_next
);

   tally_type tally_ff, tally_in;
   logic      positive;

   assign positive = !score[SCORE_BITS-1] && (score != '0);

   // bump exactly one counter per request
   always_comb begin
      tally_in = tally_ff;
      if (valid) begin
         if (truth && positive) begin
            tally_in.tp = sat_inc(tally_ff.tp);
         end else if (truth) begin
            tally_in.fn = sat_inc(tally_ff.fn);
         end else if (positive) begin
            tally_in.fp = sat_inc(tally_ff.fp);
         end else begin
            tally_in.tn = sat_inc(tally_ff.tn);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tally_ff <= '0;
      end else begin
         tally_ff <= tally_in;
      end
   end

   assign tally_next = tally_in;

endmodule
`default_nettype wire

// ===== hdl/topk_score_select_with_confusion.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// topk_score_select_with_confusion: streaming top-k selector with tallies
// Keeps the best TOP_K scores of each row and running confusion counts.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one label score per request, with is_true_label and the
//   first_of_row / last_of_row flags. A request is taken when valid and ready
//   are both high. Labels are csr_wr_data (label offset) plus the column count.
//   Inside a row one request is taken every cycle: all TOP_K cells of the
//   insertion chain compare against the new score in parallel, each deciding
//   from its own compare and a label carried combinationally down the chain.
//   A request with last_of_row copies the updated list into the shadow chain;
//   the first result shows on rsp_ch the next cycle; all TOP_K results come
//   out rank 0 first, one per cycle while rsp_ch.ready stays high.
//   While results drain req_ch.ready is low, so the next row is held until
//   the last rank is taken. A stalled receiver simply holds the current
//   result; nothing is lost.
//   Reset (synchronous) empties the list, zeroes the column count, tallies
//   and label offset, and drops any pending results. The user must write the
//   label offset through csr_wr_en / csr_wr_data only while idle (unchecked).
// ----------------------------------------------------------------------------
module topk_score_select_with_confusion import tssc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   tssc_req_if.sink                   req_ch,
   tssc_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_wr_en,
   input  wire logic [LABEL_BITS-1:0] csr_wr_data
);

   logic [LABEL_BITS-1:0] offset_ff, offset_in;
   logic [LABEL_BITS-1:0] col_ff, col_in, col_eff;
   logic                  busy_ff, busy_in;
   logic [RANK_BITS-1:0]  rank_ff, rank_in;
   tally_type             tally_next;
   tally_type             tally_out_ff;

   logic                  accept, snap, pop;
   ins_type               ins;
   entry_type             eff_ent      [TOP_K];
   entry_type             up_ent       [TOP_K];
   logic                  gt           [TOP_K];
   logic                  up_gt        [TOP_K];
   logic [LABEL_BITS-1:0] carry_lbl    [TOP_K];
   logic [LABEL_BITS-1:0] up_carry_lbl [TOP_K];
   entry_type             shadow       [TOP_K];
   entry_type             dn_shadow    [TOP_K];

   // handshakes
   assign req_ch.ready = !busy_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign snap         = accept && req_ch.last_of_row;
   assign pop          = rsp_ch.valid && rsp_ch.ready;

   // label offset register
   assign offset_in = csr_wr_en ? csr_wr_data : offset_ff;

   // column count, restarted at row start
   assign col_eff = req_ch.first_of_row ? '0 : col_ff;
   assign col_in  = accept ? col_eff + LABEL_BITS'(1) : col_ff;

   always_comb begin
      ins.valid = accept;
      ins.first = req_ch.first_of_row;
      ins.score = req_ch.score;
      ins.label = offset_ff + col_eff;
   end

   // neighbor links of the cell chain
   always_comb begin
      for (int k = 0; k < TOP_K; k++) begin
         if (k == 0) begin
            up_ent[k]       = EMPTY_ENTRY;
            up_gt[k]        = 1'b0;
            up_carry_lbl[k] = '0;
         end else begin
            up_ent[k]       = eff_ent[k-1];
            up_gt[k]        = gt[k-1];
            up_carry_lbl[k] = carry_lbl[k-1];
         end
         if (k == TOP_K - 1) begin
            dn_shadow[k] = EMPTY_ENTRY;
         end else begin
            dn_shadow[k] = shadow[k+1];
         end
      end
   end

   for (genvar k = 0; k < TOP_K; k++) begin : g_cell
      tssc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ins       (ins),
         .up_ent    (up_ent[k]),
         .up_gt     (up_gt[k]),
         .up_carry  (up_carry_lbl[k]),
         .eff_ent   (eff_ent[k]),
         .gt        (gt[k]),
         .carry     (carry_lbl[k]),
         .snap      (snap),
         .pop       (pop),
         .dn_shadow (dn_shadow[k]),
         .shadow    (shadow[k])
      );
   end

   tssc_tally u_tally (
      .clock      (clock),
      .reset      (reset),
      .valid      (accept),
      .truth      (req_ch.is_true_label),
      .score      (req_ch.score),
      .tally_next (tally_next)
   );

   // result burst control
   always_comb begin
      busy_in = busy_ff;
      rank_in = rank_ff;
      if (snap) begin
         busy_in = 1'b1;
         rank_in = '0;
      end else if (pop) begin
         if (rank_ff == LAST_RANK) begin
            busy_in = 1'b0;
         end
         rank_in = rank_ff + RANK_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         col_ff    <= '0;
         busy_ff   <= 1'b0;
         rank_ff   <= '0;
      end else begin
         offset_ff <= offset_in;
         col_ff    <= col_in;
         busy_ff   <= busy_in;
         rank_ff   <= rank_in;
      end
   end

   // tallies frozen for the burst
   always_ff @(posedge clock) begin
      if (snap) begin
         tally_out_ff <= tally_next;
      end
   end

   // result payload from the head of the shadow chain
   assign rsp_ch.valid           = busy_ff;
   assign rsp_ch.rank            = rank_ff;
   assign rsp_ch.best_score      = shadow[0].score;
   assign rsp_ch.best_label      = shadow[0].label;
   assign rsp_ch.last_rank       = (rank_ff == LAST_RANK);
   assign rsp_ch.true_pos_total  = tally_out_ff.tp;
   assign rsp_ch.false_neg_total = tally_out_ff.fn;
   assign rsp_ch.false_pos_total = tally_out_ff.fp;
   assign rsp_ch.true_neg_total  = tally_out_ff.tn;

`ifndef SYNTH
   // no request is taken while a burst drains
   assert property (@(posedge clock) disable iff (reset) rsp_ch.valid |-> !accept)
      else $error("request taken during result burst");

   // a row end starts a burst at rank zero
   assert property (@(posedge clock) disable iff (reset)
      snap |=> (rsp_ch.valid && rsp_ch.rank == '0))
      else $error("burst did not start at rank zero");

   // the final rank taken ends the burst
   assert property (@(posedge clock) disable iff (reset)
      (pop && rsp_ch.last_rank) |=> !rsp_ch.valid)
      else $error("burst continued past last rank");

   // rank advances only when a result is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> $stable(rank_ff))
      else $error("rank moved while stalled");
`endif

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for topk_score_select_with_confusion
// Streams score requests row by row and tracks the top-k list, label numbers
// and confusion tallies in a local predictor. Every ranked result is checked
// field by field against the oldest expected entry. Both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import tssc_pkg::*;

   localparam int RESET_CYCLES = 9;
   localparam int DRAIN_CYCLES = 2 * TOP_K + 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_QUOTA  = 112;
   localparam int REPORT_MAX   = 10;

   // one score request as driven
   typedef struct {
      logic [SCORE_BITS-1:0] score;
      logic                  truth;
      logic                  first;
      logic                  last;
   } score_req_type;

   // one ranked result as expected
   typedef struct {
      logic [RANK_BITS-1:0]  rank;
      logic [SCORE_BITS-1:0] score;
      logic [LABEL_BITS-1:0] label;
      logic                  last;
      tally_type             tally;
   } ranked_entry_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [LABEL_BITS-1:0] csr_wr_data;

   tssc_req_if req_ch ();
   tssc_rsp_if rsp_ch ();

   topk_score_select_with_confusion dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // stimulus and expectation stores
   score_req_type    score_feed[$];
   ranked_entry_type ranked_due[$];
   score_req_type    driven_req;

   // predictor state
   logic signed [SCORE_BITS-1:0] top_score [TOP_K];
   logic [LABEL_BITS-1:0]        top_label [TOP_K];
   logic [LABEL_BITS-1:0]        column_q;
   logic [LABEL_BITS-1:0]        label_offset_q;
   tally_type                    tally_q;

   int idle_pct        = 36;
   int requests_taken  = 0;
   int results_checked = 0;
   int mismatches      = 0;
   int cycle_count     = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // known input values from time zero
   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_ch.valid        = 1'b0;
      req_ch.score        = '0;
      req_ch.is_true_label = 1'b0;
      req_ch.first_of_row = 1'b0;
      req_ch.last_of_row  = 1'b0;
      rsp_ch.ready        = 1'b0;
   end

   // predictor: insert one request, update tallies, emit the list on row end
   function automatic void insert_score(input score_req_type r);
      logic signed [SCORE_BITS-1:0] carry_s;
      logic signed [SCORE_BITS-1:0] tmp_s;
      logic [LABEL_BITS-1:0]        carry_l;
      logic [LABEL_BITS-1:0]        tmp_l;
      logic                         positive;
      ranked_entry_type             e;
      if (r.first) begin
         for (int k = 0; k < TOP_K; k++) begin
            top_score[k] = EMPTY_SCORE;
            top_label[k] = '0;
         end
         column_q = '0;
      end
      carry_s  = r.score;
      carry_l  = label_offset_q + column_q;
      column_q = column_q + 1'b1;
      // strict compare, displaced entry moves down
      for (int k = 0; k < TOP_K; k++) begin
         if (carry_s > top_score[k]) begin
            tmp_s        = top_score[k];
            tmp_l        = top_label[k];
            top_score[k] = carry_s;
            top_label[k] = carry_l;
            carry_s      = tmp_s;
            carry_l      = tmp_l;
         end
      end
      // confusion tallies, saturating
      positive = !r.score[SCORE_BITS-1] && (r.score != '0);
      if (r.truth && positive) begin
         if (tally_q.tp != TALLY_MAX) tally_q.tp = tally_q.tp + 1'b1;
      end else if (r.truth) begin
         if (tally_q.fn != TALLY_MAX) tally_q.fn = tally_q.fn + 1'b1;
      end else if (positive) begin
         if (tally_q.fp != TALLY_MAX) tally_q.fp = tally_q.fp + 1'b1;
      end else begin
         if (tally_q.tn != TALLY_MAX) tally_q.tn = tally_q.tn + 1'b1;
      end
      if (r.last) begin
         for (int k = 0; k < TOP_K; k++) begin
            e.rank  = RANK_BITS'(k);
            e.score = top_score[k];
            e.label = top_label[k];
            e.last  = (k == TOP_K - 1);
            e.tally = tally_q;
            ranked_due = {ranked_due, e};
         end
      end
   endfunction

   // driver: hold a request until taken, then maybe idle
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            insert_score(driven_req);
            requests_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (score_feed.size() > 0 && $urandom_range(99) >= idle_pct) begin
               driven_req           = score_feed.pop_front();
               req_ch.valid         <= 1'b1;
               req_ch.score         <= driven_req.score;
               req_ch.is_true_label <= driven_req.truth;
               req_ch.first_of_row  <= driven_req.first;
               req_ch.last_of_row   <= driven_req.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random back-pressure and field-by-field check
   always @(posedge clock) begin
      ranked_entry_type e;
      logic bad;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_checked++;
            if (ranked_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected result: rank %0d score %h label %h",
                           rsp_ch.rank, rsp_ch.best_score, rsp_ch.best_label);
            end else begin
               e   = ranked_due.pop_front();
               bad = (rsp_ch.rank != e.rank) || (rsp_ch.best_score != e.score) ||
                     (rsp_ch.best_label != e.label) || (rsp_ch.last_rank != e.last) ||
                     (rsp_ch.true_pos_total != e.tally.tp) ||
                     (rsp_ch.false_neg_total != e.tally.fn) ||
                     (rsp_ch.false_pos_total != e.tally.fp) ||
                     (rsp_ch.true_neg_total != e.tally.tn);
               if (bad) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $display("exp: rank %0d score %h label %h last %0d tally %0d %0d %0d %0d",
                              e.rank, e.score, e.label, e.last,
                              e.tally.tp, e.tally.fn, e.tally.fp, e.tally.tn);
                     $display("got: rank %0d score %h label %h last %0d tally %0d %0d %0d %0d",
                              rsp_ch.rank, rsp_ch.best_score, rsp_ch.best_label,
                              rsp_ch.last_rank, rsp_ch.true_pos_total,
                              rsp_ch.false_neg_total, rsp_ch.false_pos_total,
                              rsp_ch.true_neg_total);
                  end
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("topk_score_select_with_confusion regression: fail");
         $finish;
      end
   end

   task automatic queue_score(input logic [SCORE_BITS-1:0] s, input logic t,
                              input logic f, input logic l);
      score_req_type r;
      r.score = s;
      r.truth = t;
      r.first = f;
      r.last  = l;
      score_feed = {score_feed, r};
   endtask

   // sender pauses until every expected result is back, then settles
   task automatic wait_drained();
      @(negedge clock);
      while (score_feed.size() > 0 || req_ch.valid || ranked_due.size() > 0 || rsp_ch.valid)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_offset(input logic [LABEL_BITS-1:0] v);
      @(posedge clock);
      csr_wr_en      <= 1'b1;
      csr_wr_data    <= v;
      label_offset_q = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // score mix: extremes, zero, ties, near-zero and full range
   function automatic logic [SCORE_BITS-1:0] pick_score(input logic [SCORE_BITS-1:0] prev);
      case ($urandom_range(9))
         0:       return EMPTY_SCORE;
         1:       return {1'b0, {(SCORE_BITS-1){1'b1}}};
         2:       return '0;
         3:       return prev;
         4, 5:    return SCORE_BITS'($urandom_range(256)) - SCORE_BITS'(128);
         default: return $urandom();
      endcase
   endfunction

   task automatic queue_random_rows(input int quota);
      int n;
      int len;
      logic noise;
      logic [SCORE_BITS-1:0] s;
      n = 0;
      s = '0;
      while (n < quota) begin
         len   = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 7);
         noise = ($urandom_range(9) == 0);
         for (int j = 0; j < len; j++) begin
            s = pick_score(s);
            if (noise)
               queue_score(s, 1'($urandom_range(1)), $urandom_range(3) == 0,
                           $urandom_range(3) == 0);
            else
               queue_score(s, 1'($urandom_range(1)), j == 0, j == len - 1);
         end
         n += len;
      end
   endtask

   // main sequence
   initial begin
      for (int k = 0; k < TOP_K; k++) begin
         top_score[k] = EMPTY_SCORE;
         top_label[k] = '0;
      end
      column_q       = '0;
      label_offset_q = '0;
      tally_q        = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed row: empty marker never enters, zero is not positive, ties keep
      // the earlier label, more scores than list entries
      write_offset('0);
      queue_score(EMPTY_SCORE,  1'b1, 1'b1, 1'b0);
      queue_score(32'h0,        1'b0, 1'b0, 1'b0);
      queue_score(32'h1,        1'b1, 1'b0, 1'b0);
      queue_score(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
      queue_score(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
      queue_score(32'h1,        1'b0, 1'b0, 1'b0);
      queue_score(32'h0001_0000, 1'b0, 1'b0, 1'b1);
      // continues after row end without a new first
      queue_score(32'h5,        1'b1, 1'b0, 1'b1);
      // first and last on one request
      queue_score(EMPTY_SCORE,  1'b0, 1'b1, 1'b1);
      queue_score(32'h1234_5678, 1'b1, 1'b1, 1'b1);
      queue_score(32'h8000_0001, 1'b1, 1'b1, 1'b1);
      wait_drained();

      // labels wrap past the top of the label range
      write_offset(24'hFF_FFFE);
      queue_score(32'h0000_0010, 1'b0, 1'b1, 1'b0);
      queue_score(32'h0000_0020, 1'b1, 1'b0, 1'b0);
      queue_score(32'h0000_0030, 1'b0, 1'b0, 1'b0);
      queue_score(32'h0000_0040, 1'b1, 1'b0, 1'b1);
      wait_drained();

      // random rows under several offsets, one phase without idling
      write_offset(LABEL_BITS'($urandom()));
      queue_random_rows(PHASE_QUOTA);
      wait_drained();

      write_offset('0);
      idle_pct = 0;
      queue_random_rows(PHASE_QUOTA);
      wait_drained();

      write_offset({LABEL_BITS{1'b1}});
      idle_pct = 36;
      queue_random_rows(PHASE_QUOTA);
      wait_drained();

      write_offset(LABEL_BITS'($urandom()));
      queue_random_rows(PHASE_QUOTA);
      wait_drained();

      $display("covered %0d score requests and %0d ranked results in %0d cycles,",
               requests_taken, results_checked, cycle_count);
      $display("label offsets zero, top of range and random, with and without stalls");
      if (mismatches == 0) begin
         $display("topk_score_select_with_confusion regression: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("topk_score_select_with_confusion regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/tssc_pkg.sv
hdl/tssc_req_if.sv
hdl/tssc_rsp_if.sv
hdl/tssc_cell.sv
hdl/tssc_tally.sv
hdl/topk_score_select_with_confusion.sv
bench/testbench.sv
